### sv/stereo_peaking_eq_cascade_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the stereo peaking equalizer cascade
// ---------------------------------------------------------------------------
`ifndef STEREO_PEAKING_EQ_CASCADE_DEFINES_SVH
`define STEREO_PEAKING_EQ_CASCADE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SPEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("speq assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SPEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("speq assertion failed");

`endif

### sv/speq_pkg.sv
// ---------------------------------------------------------------------------
// speq_pkg
// Shared constants, operand codes and the controller command bundle of the
// stereo peaking equalizer cascade.
// ---------------------------------------------------------------------------
`default_nettype none

package speq_pkg;

    // Storage sizes
    localparam int MAX_BANDS    = 4;
    localparam int BAND_W       = 2;
    localparam int NUM_CH       = 2;
    localparam int COEF_W       = 32;
    localparam int DLY_W        = 48;
    localparam int ACC_W        = 64;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_NUM_REGS = 2 * MAX_BANDS;
    localparam int DLY_FRAC     = 40;

    // Parameter defaults
    localparam int DEF_NUM_BANDS   = 4;
    localparam int DEF_SAMPLE_BITS = 24;

    // Register reset values: unity section
    localparam logic [CFG_W-1:0] FEED_RESET = 64'h1000_0000_0000_0000;
    localparam logic [CFG_W-1:0] BACK_RESET = 64'h0;

    // Register kind, taken from the low bit of the register index
    localparam logic KIND_FEED = 1'b0;
    localparam logic KIND_BACK = 1'b1;

    // Channel codes
    localparam logic CH_LEFT  = 1'b0;
    localparam logic CH_RIGHT = 1'b1;

    // Delay term limits, Q8.40
    localparam logic signed [ACC_W-1:0] DLY_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] DLY_MIN = 64'shFFFF_8000_0000_0000;

    // Multiplier operand pairs
    typedef enum logic [2:0] {
        MS_B0X = 3'd0,
        MS_A1X = 3'd1,
        MS_B2X = 3'd2,
        MS_A1Y = 3'd3,
        MS_A2Y = 3'd4
    } t_msel;

    // Controller to datapath commands
    typedef struct packed {
        logic              load_in;
        t_msel             mul_sel;
        logic              acc_y;
        logic              calc_y;
        logic              init_z1;
        logic              init_z2;
        logic              sub_z1;
        logic              sub_z2;
        logic              write_back;
        logic              out_load;
        logic [BAND_W-1:0] band;
        logic              ch;
    } t_dp_cmd;

endpackage

`default_nettype wire

### sv/stereo_peaking_eq_cascade.sv
// ---------------------------------------------------------------------------
// stereo_peaking_eq_cascade
// Stereo cascade of transposed direct form II peaking biquads, Q4.28
// coefficients shared by both channels, 48-bit saturating delay terms.
// ---------------------------------------------------------------------------
//  channel | signals                               | request
//  input   | i_in_valid / o_in_ready               | left and right sample pair
//  output  | o_out_valid / i_out_ready             | equalized sample pair
//  config  | i_cfg_valid / o_cfg_ready             | index and 64-bit coefficients
//
// The single shared multiplier sets the pace of a sample pair: five products
// per section and channel, plus a final subtract and a delay write-back.
// Reset loads every band as unity, clears all delay terms and empties the
// output register. The result waits in the output register while the next
// pair is taken; a pair that finishes before that result is taken holds.
// ---------------------------------------------------------------------------
`default_nettype none

`include "stereo_peaking_eq_cascade_defines.svh"

module stereo_peaking_eq_cascade #(
    parameter int NUM_BANDS   = speq_pkg::DEF_NUM_BANDS,
    parameter int SAMPLE_BITS = speq_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]  i_left_in,
    input  wire logic signed [SAMPLE_BITS-1:0]  i_right_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]       o_left_out,
    output logic signed [SAMPLE_BITS-1:0]       o_right_out,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [speq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [speq_pkg::CFG_W-1:0]     i_cfg_data
);
    import speq_pkg::*;

    t_dp_cmd w_cmd;
    logic    w_cfg_we;

    // Configuration is always taken
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    speq_ctrl #(
        .NUM_BANDS (NUM_BANDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    speq_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_left_in   (i_left_in),
        .i_right_in  (i_right_in),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out)
    );

    // Busy right after a request is taken
    `SPEQ_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    // Never overwrite a result that is still waiting
    `SPEQ_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load, !o_out_valid || i_out_ready)
    // Write-back only touches configured bands
    `SPEQ_ASSERT_NOW(a_band_range, i_clk, i_rst_n, w_cmd.write_back, w_cmd.band <= BAND_W'(NUM_BANDS - 1))

endmodule

`default_nettype wire

### sv/speq_ctrl.sv
// ---------------------------------------------------------------------------
// speq_ctrl
// Sequencer of the equalizer: walks every band and channel through the
// multiply schedule of one section and owns the request handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

module speq_ctrl #(
    parameter int NUM_BANDS = speq_pkg::DEF_NUM_BANDS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output speq_pkg::t_dp_cmd      o_cmd
);
    import speq_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MB0   = 9'b000000010,
        ST_MA1X  = 9'b000000100,
        ST_MB2   = 9'b000001000,
        ST_MA1Y  = 9'b000010000,
        ST_MA2Y  = 9'b000100000,
        ST_SUBZ2 = 9'b001000000,
        ST_WB    = 9'b010000000,
        ST_DONE  = 9'b100000000
    } t_state;

    localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(NUM_BANDS - 1);

    t_state            r_state, n_state;
    logic [BAND_W-1:0] r_band, n_band;
    logic              r_ch, n_ch;
    logic              r_out_valid, n_out_valid;

    // Next state and command decode
    always_comb begin
        n_state     = r_state;
        n_band      = r_band;
        n_ch        = r_ch;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.band  = r_band;
        o_cmd.ch    = r_ch;
        o_cmd.mul_sel = MS_B0X;

        // drop the result once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_band        = '0;
                    n_ch          = CH_LEFT;
                    n_state       = ST_MB0;
                end
            end
            ST_MB0: begin
                o_cmd.mul_sel = MS_B0X;
                n_state       = ST_MA1X;
            end
            ST_MA1X: begin
                o_cmd.mul_sel = MS_A1X;
                o_cmd.acc_y   = 1'b1;
                n_state       = ST_MB2;
            end
            ST_MB2: begin
                o_cmd.mul_sel = MS_B2X;
                o_cmd.init_z1 = 1'b1;
                o_cmd.calc_y  = 1'b1;
                n_state       = ST_MA1Y;
            end
            ST_MA1Y: begin
                o_cmd.mul_sel = MS_A1Y;
                o_cmd.init_z2 = 1'b1;
                n_state       = ST_MA2Y;
            end
            ST_MA2Y: begin
                o_cmd.mul_sel = MS_A2Y;
                o_cmd.sub_z1  = 1'b1;
                n_state       = ST_SUBZ2;
            end
            ST_SUBZ2: begin
                o_cmd.sub_z2 = 1'b1;
                n_state      = ST_WB;
            end
            ST_WB: begin
                o_cmd.write_back = 1'b1;
                // advance channel, then band
                if (r_ch == CH_RIGHT) begin
                    if (r_band == LAST_BAND) begin
                        n_state = ST_DONE;
                    end else begin
                        n_band  = r_band + BAND_W'(1);
                        n_ch    = CH_LEFT;
                        n_state = ST_MB0;
                    end
                end else begin
                    n_ch    = CH_RIGHT;
                    n_state = ST_MB0;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_band      <= '0;
            r_ch        <= CH_LEFT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_band      <= n_band;
            r_ch        <= n_ch;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### sv/speq_dp.sv
// ---------------------------------------------------------------------------
// speq_dp
// Datapath of the equalizer: coefficient registers, delay terms, one shared
// signed multiplier, three accumulators and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module speq_dp #(
    parameter int SAMPLE_BITS = speq_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire speq_pkg::t_dp_cmd                 i_cmd,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_left_in,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_right_in,
    input  wire logic                              i_cfg_we,
    input  wire logic [speq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [speq_pkg::CFG_W-1:0]        i_cfg_data,
    output logic signed [SAMPLE_BITS-1:0]          o_left_out,
    output logic signed [SAMPLE_BITS-1:0]          o_right_out
);
    import speq_pkg::*;

    localparam int PROD_W      = COEF_W + SAMPLE_BITS;
    localparam int ALIGN_SHIFT = SAMPLE_BITS - 13;
    localparam int ROUND_SHIFT = DLY_FRAC - (SAMPLE_BITS - 1);
    localparam int DLY_DEPTH   = 2 * MAX_BANDS;
    localparam int K_W         = BAND_W + 1;

    localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) <<< (ROUND_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] Y_MAX = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);

    // Clamp a wide sum to the 48-bit delay range
    function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] c;
        c = v;
        if (v > DLY_MAX) c = DLY_MAX;
        if (v < DLY_MIN) c = DLY_MIN;
        return c[DLY_W-1:0];
    endfunction

    logic [CFG_W-1:0]              r_feed [MAX_BANDS];
    logic [CFG_W-1:0]              r_back [MAX_BANDS];
    logic signed [DLY_W-1:0]       r_z1d  [DLY_DEPTH];
    logic signed [DLY_W-1:0]       r_z2d  [DLY_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_x    [NUM_CH];
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc_y;
    logic signed [ACC_W-1:0]       r_z1;
    logic signed [ACC_W-1:0]       r_z2;

    logic [CFG_W-1:0]              w_feed, w_back;
    logic signed [COEF_W-1:0]      w_coef;
    logic signed [SAMPLE_BITS-1:0] w_samp;
    logic signed [SAMPLE_BITS-1:0] w_x;
    logic signed [ACC_W-1:0]       w_prod_ext, w_al, w_rnd, w_ysat;
    logic [K_W-1:0]                w_k;
    logic [BAND_W-1:0]             w_cfg_band;

    assign w_k        = {i_cmd.band, i_cmd.ch};
    assign w_feed     = r_feed[i_cmd.band];
    assign w_back     = r_back[i_cmd.band];
    assign w_x        = r_x[i_cmd.ch];
    assign w_cfg_band = i_cfg_index[BAND_W:1];

    // Select the multiplier operand pair
    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_B0X: begin
                w_coef = w_feed[2*COEF_W-1:COEF_W];
                w_samp = w_x;
            end
            MS_A1X: begin
                w_coef = w_back[2*COEF_W-1:COEF_W];
                w_samp = w_x;
            end
            MS_B2X: begin
                w_coef = w_feed[COEF_W-1:0];
                w_samp = w_x;
            end
            MS_A1Y: begin
                w_coef = w_back[2*COEF_W-1:COEF_W];
                w_samp = r_y;
            end
            MS_A2Y: begin
                w_coef = w_back[COEF_W-1:0];
                w_samp = r_y;
            end
            default: begin
                w_coef = w_feed[2*COEF_W-1:COEF_W];
                w_samp = w_x;
            end
        endcase
    end

    // Align the product to Q8.40, flooring
    assign w_prod_ext = ACC_W'(r_prod);
    assign w_al       = w_prod_ext >>> ALIGN_SHIFT;

    // Round half up and saturate the section output
    always_comb begin
        w_rnd  = (r_acc_y + HALF) >>> ROUND_SHIFT;
        w_ysat = w_rnd;
        if (w_rnd > Y_MAX) w_ysat = Y_MAX;
        if (w_rnd < Y_MIN) w_ysat = Y_MIN;
    end

    // Coefficient registers and delay terms
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < MAX_BANDS; b++) begin
                r_feed[b] <= FEED_RESET;
                r_back[b] <= BACK_RESET;
            end
            for (int d = 0; d < DLY_DEPTH; d++) begin
                r_z1d[d] <= '0;
                r_z2d[d] <= '0;
            end
        end else begin
            if (i_cfg_we && (i_cfg_index < CFG_IDX_W'(CFG_NUM_REGS))) begin
                if (i_cfg_index[0] == KIND_BACK) begin
                    r_back[w_cfg_band] <= i_cfg_data;
                end else begin
                    r_feed[w_cfg_band] <= i_cfg_data;
                end
            end
            if (i_cmd.write_back) begin
                r_z1d[w_k] <= sat_dly(r_z1);
                r_z2d[w_k] <= sat_dly(r_z2);
            end
        end
    end

    // Multiply, accumulate and carry the sample between sections
    always_ff @(posedge i_clk) begin
        r_prod <= w_coef * w_samp;
        if (i_cmd.load_in) begin
            r_x[CH_LEFT]  <= i_left_in;
            r_x[CH_RIGHT] <= i_right_in;
        end else if (i_cmd.write_back) begin
            r_x[i_cmd.ch] <= r_y;
        end
        if (i_cmd.acc_y) begin
            r_acc_y <= w_al + ACC_W'(r_z1d[w_k]);
        end
        if (i_cmd.calc_y) begin
            r_y <= w_ysat[SAMPLE_BITS-1:0];
        end
        if (i_cmd.init_z1) begin
            r_z1 <= w_al + ACC_W'(r_z2d[w_k]);
        end else if (i_cmd.sub_z1) begin
            r_z1 <= r_z1 - w_al;
        end
        if (i_cmd.init_z2) begin
            r_z2 <= w_al;
        end else if (i_cmd.sub_z2) begin
            r_z2 <= r_z2 - w_al;
        end
        // publish the finished pair
        if (i_cmd.out_load) begin
            o_left_out  <= r_x[CH_LEFT];
            o_right_out <= r_x[CH_RIGHT];
        end
    end

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stereo peaking EQ cascade testbench
// Drives sample pairs and coefficient writes over valid/ready channels with
// random idle cycles. A scoreboard runs a bit-exact model of the biquad
// cascade and checks every equalized pair in order.
// ---------------------------------------------------------------------------
module testbench;

    import speq_pkg::*;

    localparam int NUM_BANDS       = DEF_NUM_BANDS;
    localparam int SAMPLE_BITS     = DEF_SAMPLE_BITS;
    localparam int ALIGN_SHIFT     = SAMPLE_BITS - 13;
    localparam int ROUND_SHIFT     = DLY_FRAC - (SAMPLE_BITS - 1);
    localparam int IDLE_PCT        = 15;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 88;
    localparam int CALM_PHASE      = 3;
    localparam int PAUSE_PHASE     = 1;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int TAIL_CYCLES     = 64;
    localparam int MAX_REPORTS     = 40;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef struct packed {
        t_sample left;
        t_sample right;
    } t_stereo;
    typedef enum int { COEF_BOOST, COEF_MAX, COEF_MIN, COEF_RANDOM } t_coef_style;

    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Stable boost section: b0 3.0, b2 0.5, a1 -1.5, a2 0.625
    localparam logic [COEF_W-1:0] BOOST_B0    = 32'h3000_0000;
    localparam logic [COEF_W-1:0] BOOST_B2    = 32'h0800_0000;
    localparam logic [COEF_W-1:0] BOOST_A1    = 32'hE800_0000;
    localparam logic [COEF_W-1:0] BOOST_A2    = 32'h0A00_0000;
    localparam logic [COEF_W-1:0] COEF_TOP    = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] COEF_BOTTOM = 32'h8000_0000;

    // Cascade model and in-order result checker
    class t_eq_scoreboard;
        logic [CFG_W-1:0] feed_coefs [MAX_BANDS];
        logic [CFG_W-1:0] back_coefs [MAX_BANDS];
        longint           first_dly  [NUM_CH*MAX_BANDS];
        longint           second_dly [NUM_CH*MAX_BANDS];
        t_stereo          expected_pairs [$];
        int               errors;

        function void clear_state();
            for (int b = 0; b < MAX_BANDS; b++) begin
                feed_coefs[b] = FEED_RESET;
                back_coefs[b] = BACK_RESET;
            end
            for (int k = 0; k < NUM_CH*MAX_BANDS; k++) begin
                first_dly[k]  = 0;
                second_dly[k] = 0;
            end
            expected_pairs.delete();
            errors = 0;
        endfunction

        // Drop writes to indexes past the register list
        function void store_coefs(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (int'(idx) < CFG_NUM_REGS) begin
                if (idx[0] == KIND_BACK) begin
                    back_coefs[idx[CFG_IDX_W-1:1]] = data;
                end else begin
                    feed_coefs[idx[CFG_IDX_W-1:1]] = data;
                end
            end
        endfunction

        // Exact product, aligned to Q8.40 with a floor shift
        function longint scaled(longint c, longint x);
            return (c * x) >>> ALIGN_SHIFT;
        endfunction

        function longint clamp_delay(longint v);
            if (v > DLY_MAX) return DLY_MAX;
            if (v < DLY_MIN) return DLY_MIN;
            return v;
        endfunction

        function longint biquad(int band, logic ch, longint x);
            longint b0, b2, a1, a2, acc, y;
            int     k;
            b0  = longint'($signed(feed_coefs[band][CFG_W-1:COEF_W]));
            b2  = longint'($signed(feed_coefs[band][COEF_W-1:0]));
            a1  = longint'($signed(back_coefs[band][CFG_W-1:COEF_W]));
            a2  = longint'($signed(back_coefs[band][COEF_W-1:0]));
            k   = NUM_CH * band + int'(ch);
            acc = scaled(b0, x) + first_dly[k];
            // round half up, then saturate to the sample range
            y   = (acc + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
            if (y > longint'(SAMPLE_MAX)) y = longint'(SAMPLE_MAX);
            if (y < longint'(SAMPLE_MIN)) y = longint'(SAMPLE_MIN);
            // first delay takes the old second delay
            first_dly[k]  = clamp_delay(scaled(a1, x) - scaled(a1, y) + second_dly[k]);
            second_dly[k] = clamp_delay(scaled(b2, x) - scaled(a2, y));
            return y;
        endfunction

        function void note_input(t_sample l, t_sample r);
            longint  lv, rv;
            t_stereo want;
            lv = l;
            rv = r;
            for (int b = 0; b < NUM_BANDS; b++) begin
                lv = biquad(b, CH_LEFT, lv);
                rv = biquad(b, CH_RIGHT, rv);
            end
            want.left  = t_sample'(lv);
            want.right = t_sample'(rv);
            expected_pairs.insert(expected_pairs.size(), want);
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        task check_result(t_sample l, t_sample r);
            t_stereo want;
            if (expected_pairs.size() == 0) begin
                report($sformatf("result L=%0d R=%0d with no sample pending", l, r));
                return;
            end
            want = expected_pairs.pop_front();
            if (l !== want.left)
                report($sformatf("left_out got %0d, want %0d", l, want.left));
            if (r !== want.right)
                report($sformatf("right_out got %0d, want %0d", r, want.right));
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    t_sample                i_left_in   = '0;
    t_sample                i_right_in  = '0;
    logic                   i_out_ready = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]       i_cfg_data  = '0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    t_sample                o_left_out;
    t_sample                o_right_out;
    logic                   o_cfg_ready;

    bit                     calm_stretch = 1'b0;
    int                     idle_cycles  = 0;
    int                     pairs_sent   = 0;
    int                     pairs_done   = 0;
    t_eq_scoreboard         sb;

    stereo_peaking_eq_cascade #(
        .NUM_BANDS   (NUM_BANDS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_left_in   (i_left_in),
        .i_right_in  (i_right_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result side at random, except during the calm stretch
    always @(posedge i_clk) begin
        i_out_ready <= calm_stretch || ($urandom_range(99) >= IDLE_PCT);
    end

    // Track every handshake on all three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.store_coefs(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) sb.note_input(i_left_in, i_right_in);
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_left_out, o_right_out);
                pairs_done++;
            end
        end
    end

    // Abort when no channel moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_sample small_sample();
        return t_sample'(int'($urandom_range(8191)) - 4096);
    endfunction

    function automatic t_sample extreme_sample();
        case ($urandom_range(3))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic [CFG_IDX_W-1:0] band_reg(int band, logic kind);
        return CFG_IDX_W'(2 * band + int'(kind));
    endfunction

    task automatic send_pair(t_sample l, t_sample r);
        // idle the request line now and then
        while (!calm_stretch && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_left_in  <= l;
        i_right_in <= r;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        pairs_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        while (!calm_stretch && $urandom_range(99) < IDLE_PCT) begin
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
    endtask

    // Hold off new samples until every pending result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pairs_done < pairs_sent) @(posedge i_clk);
    endtask

    task automatic program_bands(t_coef_style style, int junk_writes);
        logic [CFG_W-1:0]  feed, back;
        logic [COEF_W-1:0] b0, b2, a1, a2;
        // writes past the register list must leave the bands alone
        for (int j = 0; j < junk_writes; j++)
            write_reg(CFG_IDX_W'(CFG_NUM_REGS + j % CFG_NUM_REGS), {$urandom, $urandom});
        for (int b = 0; b < MAX_BANDS; b++) begin
            case (style)
                COEF_BOOST: begin
                    feed = {BOOST_B0, BOOST_B2};
                    back = {BOOST_A1, BOOST_A2};
                end
                COEF_MAX: begin
                    feed = {COEF_TOP, COEF_TOP};
                    back = {COEF_TOP, COEF_TOP};
                end
                COEF_MIN: begin
                    feed = {COEF_BOTTOM, COEF_BOTTOM};
                    back = {COEF_BOTTOM, COEF_BOTTOM};
                end
                default: begin
                    case ($urandom_range(9))
                        0, 1: begin
                            feed = FEED_RESET;
                            back = BACK_RESET;
                        end
                        8, 9: begin
                            feed = {$urandom, $urandom};
                            back = {$urandom, $urandom};
                        end
                        default: begin
                            // stable peaking-like section
                            b0   = $urandom_range(32'h1400_0000, 32'h0C00_0000);
                            b2   = $urandom_range(32'h1200_0000, 32'h0800_0000);
                            a1   = 32'd0 - $urandom_range(32'h1D99_999A, 32'h1333_3333);
                            a2   = $urandom_range(32'h0FAE_147A, 32'h0E66_6666);
                            feed = {b0, b2};
                            back = {a1, a2};
                        end
                    endcase
                end
            endcase
            write_reg(band_reg(b, KIND_FEED), feed);
            write_reg(band_reg(b, KIND_BACK), back);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        t_sample l, r;
        sb = new;
        sb.clear_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Unity bands after reset: samples pass through
        send_pair('0, '0);
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        send_pair(t_sample'(24'h555555), t_sample'(24'hAAAAAA));
        send_pair('1, t_sample'(1));
        send_pair(t_sample'(12345), '0);
        drain();

        // Boost: full-scale input overflows the section output
        program_bands(COEF_BOOST, CFG_NUM_REGS);
        send_pair(SAMPLE_MAX, SAMPLE_MAX);
        send_pair(SAMPLE_MIN, SAMPLE_MIN);
        send_pair(SAMPLE_MAX, '0);
        send_pair('0, '0);
        send_pair('0, '0);
        send_pair(t_sample'(1000), t_sample'(-1000));
        drain();

        // Extreme coefficients: drive the delay terms into saturation
        program_bands(COEF_MAX, 0);
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(SAMPLE_MIN, SAMPLE_MAX);
        send_pair(SAMPLE_MAX, SAMPLE_MAX);
        send_pair('0, '0);
        send_pair(t_sample'(-7), t_sample'(7));
        drain();
        program_bands(COEF_MIN, 0);
        send_pair(SAMPLE_MAX, SAMPLE_MIN);
        send_pair(SAMPLE_MIN, SAMPLE_MIN);
        send_pair('0, SAMPLE_MAX);
        send_pair('1, '0);
        drain();

        // Random phases with fresh coefficients each time
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            program_bands(COEF_RANDOM, $urandom_range(2));
            calm_stretch <= (p == CALM_PHASE);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2) drain();
                l = t_sample'($urandom);
                r = t_sample'($urandom);
                case ($urandom_range(9))
                    5, 6: begin
                        l = small_sample();
                        r = small_sample();
                    end
                    7: r = '0;
                    8: begin
                        l = extreme_sample();
                        r = extreme_sample();
                    end
                    9: begin
                        l = small_sample();
                        r = '0;
                    end
                    default: ;
                endcase
                send_pair(l, r);
            end
            drain();
        end

        // Catch any stray result after the last one
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
